@@ rtl/core/nph_pkg.sv @@
// Package with shared types and constants of the nucleotide pair histogram.
package nph_pkg;

   localparam logic [1:0] FUNC_CHAR   = 2'd0;
   localparam logic [1:0] FUNC_EOL    = 2'd1;
   localparam logic [1:0] FUNC_REPORT = 2'd2;

   localparam logic [2:0] CLASS_A     = 3'd0;
   localparam logic [2:0] CLASS_C     = 3'd1;
   localparam logic [2:0] CLASS_T     = 3'd2;
   localparam logic [2:0] CLASS_G     = 3'd3;
   localparam logic [2:0] CLASS_OTHER = 3'd4;

   localparam logic [4:0] LAST_INDEX  = 5'd22;

   // A classified word handed from the front to the back.
   typedef struct packed {
      logic [1:0] func;
      logic [2:0] cls;
   } cmd_type;

   function automatic logic [2:0] classify(input logic [7:0] sym);
      logic [2:0] c;
      case (sym)
         8'h41:   c = CLASS_A;
         8'h43:   c = CLASS_C;
         8'h54:   c = CLASS_T;
         8'h47:   c = CLASS_G;
         default: c = CLASS_OTHER;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/nph_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface nph_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] symbol;
   modport source (output valid, func, symbol, input ready);
   modport sink   (input valid, func, symbol, output ready);
endinterface

interface nph_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  item_index;
   logic [63:0] count_value;
   logic        last_item;
   modport source (output valid, item_index, count_value, last_item, input ready);
   modport sink   (input valid, item_index, count_value, last_item, output ready);
endinterface

@@ rtl/core/nph_front.sv @@
// Front end: accepts request words, classifies them and queues them.
module nph_front (
   input  logic              clock,
   input  logic              reset,
   nph_req_if.sink           req,
   output nph_pkg::cmd_type  cmd_data,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import nph_pkg::*;

   // Two-entry queue.
   cmd_type    entry_ff [2];
   cmd_type    entry_in;
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       push, pop;

   assign req.ready  = (count_ff != 2'd2);
   // Unused func code three is dropped here.
   assign push       = req.valid && req.ready && (req.func != 2'd3);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd_data   = entry_ff[rd_ptr_ff];
   assign entry_in   = '{func: req.func, cls: classify(req.symbol)};

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count lost a push");

endmodule

@@ rtl/core/nph_back.sv @@
// Back end: updates line and total counters and streams out reports.
module nph_back #(
   parameter int COUNT_WIDTH = 32,
   parameter int LINE_WIDTH  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  nph_pkg::cmd_type  cmd_data,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   nph_rsp_if.source         rsp
);
   import nph_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [LINE_WIDTH-1:0]  LMAX = '1;
   // Sums are formed wide enough for either operand, so a line count wider than
   // a total still saturates the total correctly.
   localparam int SUM_WIDTH =
      ((COUNT_WIDTH > LINE_WIDTH) ? COUNT_WIDTH : LINE_WIDTH) + 1;
   localparam logic [SUM_WIDTH-1:0] CMAX_WIDE = SUM_WIDTH'(CMAX);

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_COMMIT = 2'd1;
   localparam logic [1:0] ST_REPORT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [4:0]             idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] chars_ff, lines_ff;
   logic [63:0]            sq_ff, sq_in;
   logic [COUNT_WIDTH-1:0] tot_ff [20];
   logic [LINE_WIDTH-1:0]  len_ff;
   logic [LINE_WIDTH-1:0]  lcnt_ff [20];
   logic [3:0]             seen_ff;
   logic [3:0]             hc_ff, ht_ff;
   logic [2*LINE_WIDTH-1:0] lsq_ff;
   logic                   rsp_valid_ff;
   logic [4:0]             rsp_idx_ff;
   logic [63:0]            rsp_val_ff;
   logic                   rsp_last_ff;
   logic                   take, out_free;
   logic [64:0]            sq_sum;
   logic [63:0]            rd_val;
   logic [SUM_WIDTH-1:0]   chars_sum;
   logic [3:0]             pidx;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cmd_ready = (state_ff == ST_RUN);
   assign take      = cmd_valid && cmd_ready;
   assign pidx      = {ht_ff[1:0], cmd_data.cls[1:0]};
   assign sq_sum    = {1'b0, sq_ff} + 65'(lsq_ff);
   assign sq_in     = sq_sum[64] ? '1 : sq_sum[63:0];
   assign chars_sum = SUM_WIDTH'(chars_ff) + SUM_WIDTH'(len_ff);

   always_comb begin
      case (idx_ff)
         5'd0:    rd_val = 64'(chars_ff);
         5'd1:    rd_val = 64'(lines_ff);
         5'd2:    rd_val = sq_ff;
         default: rd_val = 64'(tot_ff[5'(idx_ff - 5'd3)]);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_RUN: begin
            if (take && cmd_data.func == FUNC_EOL) begin
               state_in = ST_COMMIT;
            end else if (take && cmd_data.func == FUNC_REPORT) begin
               state_in = ST_REPORT;
               idx_in   = 5'd0;
            end
         end
         ST_COMMIT: state_in = ST_RUN;
         ST_REPORT: begin
            if (out_free) begin
               idx_in = idx_ff + 5'd1;
               if (idx_ff == LAST_INDEX) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         idx_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         chars_ff     <= '0;
         lines_ff     <= '0;
         sq_ff        <= '0;
         len_ff       <= '0;
         seen_ff      <= '0;
         hc_ff        <= '0;
         ht_ff        <= '0;
         for (int i = 0; i < 20; i++) begin
            tot_ff[i]  <= '0;
            lcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (state_ff == ST_REPORT && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_idx_ff   <= idx_ff;
            rsp_val_ff   <= rd_val;
            rsp_last_ff  <= (idx_ff == LAST_INDEX);
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take && cmd_data.func == FUNC_CHAR) begin
            if (len_ff != LMAX) len_ff <= len_ff + 1'b1;
            if (!cmd_data.cls[2]) begin
               if (lcnt_ff[cmd_data.cls[1:0]] != LMAX)
                  lcnt_ff[cmd_data.cls[1:0]] <= lcnt_ff[cmd_data.cls[1:0]] + 1'b1;
               seen_ff[cmd_data.cls[1:0]] <= 1'b1;
            end
            if (ht_ff[3]) begin
               if (!ht_ff[2] && !cmd_data.cls[2] && lcnt_ff[5'd4 + 5'(pidx)] != LMAX)
                  lcnt_ff[5'd4 + 5'(pidx)] <= lcnt_ff[5'd4 + 5'(pidx)] + 1'b1;
               ht_ff <= 4'd0;
            end else begin
               ht_ff <= {1'b1, cmd_data.cls};
            end
         end
         // Square of the line length is formed on the end-of-line cycle,
         // and the line is committed in the following cycle.
         if (take && cmd_data.func == FUNC_EOL) begin
            lsq_ff <= (2*LINE_WIDTH)'(len_ff) * (2*LINE_WIDTH)'(len_ff);
         end
         if (state_ff == ST_COMMIT) begin
            if (seen_ff == 4'hF) begin
               chars_ff <= (chars_sum > CMAX_WIDE) ? CMAX : chars_sum[COUNT_WIDTH-1:0];
               if (lines_ff != CMAX) lines_ff <= lines_ff + 1'b1;
               sq_ff <= sq_in;
               for (int i = 0; i < 20; i++) begin
                  logic [SUM_WIDTH-1:0] s;
                  s = SUM_WIDTH'(tot_ff[i]) + SUM_WIDTH'(lcnt_ff[i]);
                  tot_ff[i] <= (s > CMAX_WIDE) ? CMAX : s[COUNT_WIDTH-1:0];
               end
               hc_ff <= ht_ff;
            end else begin
               ht_ff <= hc_ff;
            end
            len_ff  <= '0;
            seen_ff <= '0;
            for (int i = 0; i < 20; i++) lcnt_ff[i] <= '0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.item_index  = rsp_idx_ff;
   assign rsp.count_value = rsp_val_ff;
   assign rsp.last_item   = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (len_ff == '0 && seen_ff == 4'd0))
      else $error("line state not cleared after commit");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> !cmd_ready)
      else $error("command taken during report");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_item) |-> (rsp.item_index == LAST_INDEX))
      else $error("last flag on wrong item");

endmodule

@@ rtl/core/nucleotide_pair_histogram.sv @@
// Top level of the nucleotide pair histogram.
// Channel | Dir | Fields                                 | Word
// req     | in  | func[1:0], symbol[7:0]                 | one character, end of line or report
// rsp     | out | item_index[4:0], count_value[63:0], last_item | one count
// A character is taken directly; an end of line squares the line length, then commits the line.
// A report holds the back end until its 23 count words are sent, response stalls included.
// A two-word queue between front and back lets requests enter while the back is busy.
// Reset is synchronous and clears all counters at once; no clearing pass.
module nucleotide_pair_histogram #(
   parameter int COUNT_WIDTH = 32,
   parameter int LINE_WIDTH  = 16
) (
   input logic     clock,
   input logic     reset,
   nph_req_if.sink   req,
   nph_rsp_if.source rsp
);
   import nph_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid, cmd_ready;

   nph_front u_front (
      .clock, .reset, .req,
      .cmd_data, .cmd_valid, .cmd_ready
   );

   nph_back #(.COUNT_WIDTH(COUNT_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_back (
      .clock, .reset,
      .cmd_data, .cmd_valid, .cmd_ready, .rsp
   );

endmodule

@@ tb/sv/nucleotide_pair_histogram_test.sv @@
// Self-checking testbench of the nucleotide pair histogram block.
`timescale 1ns / 1ps

module nucleotide_pair_histogram_test;
   import nph_pkg::*;

   typedef struct {
      logic [1:0] func;
      logic [7:0] symbol;
      bit         drain;
   } word_type;

   typedef struct {
      logic [4:0]  item_index;
      logic [63:0] count_value;
      logic        last_item;
   } count_word_type;

   localparam logic [63:0] COUNT_TOP = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] LINE_TOP  = 64'h0000_0000_0000_FFFF;
   localparam logic [63:0] WIDE_TOP  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam int          CYCLE_LIMIT = 300000;

   logic clock;
   logic reset;

   nph_req_if req_ch ();
   nph_rsp_if rsp_ch ();

   nucleotide_pair_histogram dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   word_type       pending_words[$];
   count_word_type expected_counts[$];
   int          fail_count = 0;
   int          report_count = 0;
   int          cycle_count = 0;

   // Histogram state mirrored from the block's behavior.
   logic [63:0] kept_chars, kept_lines, square_sum;
   logic [63:0] letter_tot[4];
   logic [63:0] pair_tot[16];
   logic [63:0] line_len;
   logic [63:0] line_letters[4];
   logic [63:0] line_pairs[16];
   logic [3:0]  letters_seen;
   logic [3:0]  held_kept, held_line;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, top}) ? top : s[63:0];
   endfunction

   function automatic logic [2:0] letter_class(logic [7:0] sym);
      case (sym)
         "A":     return CLASS_A;
         "C":     return CLASS_C;
         "T":     return CLASS_T;
         "G":     return CLASS_G;
         default: return CLASS_OTHER;
      endcase
   endfunction

   task automatic clear_histogram();
      kept_chars = '0;
      kept_lines = '0;
      square_sum = '0;
      for (int i = 0; i < 4; i++) letter_tot[i] = '0;
      for (int i = 0; i < 16; i++) pair_tot[i] = '0;
      held_kept = '0;
      held_line = '0;
      line_len = '0;
      letters_seen = '0;
      for (int i = 0; i < 4; i++) line_letters[i] = '0;
      for (int i = 0; i < 16; i++) line_pairs[i] = '0;
   endtask

   task automatic update_histogram(word_type w);
      logic [2:0]  cls;
      logic [2:0]  first;
      count_word_type c;
      if (w.func == FUNC_CHAR) begin
         cls = letter_class(w.symbol);
         line_len = sat_add(line_len, 64'd1, LINE_TOP);
         if (cls != CLASS_OTHER) begin
            line_letters[cls] = sat_add(line_letters[cls], 64'd1, LINE_TOP);
            letters_seen[cls] = 1'b1;
         end
         if (held_line[3]) begin
            first = held_line[2:0];
            if (first != CLASS_OTHER && cls != CLASS_OTHER)
               line_pairs[first * 4 + cls] = sat_add(line_pairs[first * 4 + cls], 64'd1,
                                                     LINE_TOP);
            held_line = '0;
         end else begin
            held_line = {1'b1, cls};
         end
      end else if (w.func == FUNC_EOL) begin
         // Only a line with all four letters reaches the totals.
         if (letters_seen == 4'hF) begin
            kept_chars = sat_add(kept_chars, line_len, COUNT_TOP);
            kept_lines = sat_add(kept_lines, 64'd1, COUNT_TOP);
            square_sum = sat_add(square_sum, line_len * line_len, WIDE_TOP);
            for (int i = 0; i < 4; i++)
               letter_tot[i] = sat_add(letter_tot[i], line_letters[i], COUNT_TOP);
            for (int i = 0; i < 16; i++)
               pair_tot[i] = sat_add(pair_tot[i], line_pairs[i], COUNT_TOP);
            held_kept = held_line;
         end
         line_len = '0;
         letters_seen = '0;
         for (int i = 0; i < 4; i++) line_letters[i] = '0;
         for (int i = 0; i < 16; i++) line_pairs[i] = '0;
         held_line = held_kept;
      end else if (w.func == FUNC_REPORT) begin
         report_count++;
         for (int k = 0; k < 23; k++) begin
            c.item_index = k[4:0];
            if (k == 0) c.count_value = kept_chars;
            else if (k == 1) c.count_value = kept_lines;
            else if (k == 2) c.count_value = square_sum;
            else if (k < 7) c.count_value = letter_tot[k - 3];
            else c.count_value = pair_tot[k - 7];
            c.last_item = (k[4:0] == LAST_INDEX);
            expected_counts.push_back(c);
         end
      end
   endtask

   // Stimulus construction.
   function automatic logic [7:0] pick_letter(int k);
      case (k)
         0:       return "A";
         1:       return "C";
         2:       return "T";
         default: return "G";
      endcase
   endfunction

   task automatic add_word(logic [1:0] func, logic [7:0] symbol, bit drain = 0);
      word_type w;
      w.func = func;
      w.symbol = symbol;
      w.drain = drain;
      pending_words.push_back(w);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_word(FUNC_CHAR, s[i]);
   endtask

   task automatic add_random_line(bit wants_all);
      int len;
      int missing;
      int k;
      len = $urandom_range(4, 24);
      missing = wants_all ? 4 : $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_word(FUNC_CHAR, 8'($urandom_range(0, 255)));
         end else begin
            k = $urandom_range(0, 3);
            if (k == missing) k = (k + 1) % 4;
            add_word(FUNC_CHAR, pick_letter(k));
         end
      end
      // Make a well-formed line hold every letter.
      if (wants_all) add_text("ACGT");
      add_word(FUNC_EOL, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_CHAR;
      req_ch.symbol = 8'h00;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      clock = 1'b0;
      clear_histogram();

      // Directed part: empty report, minimal line, odd line, a rejected line, noise.
      add_word(FUNC_REPORT, 8'h00);
      add_text("ACGT");
      add_word(FUNC_EOL, 8'hFF);
      add_text("AaCGTx");
      add_word(FUNC_CHAR, 8'hFF);
      add_word(FUNC_EOL, 8'h00);
      add_text("GACAT");
      add_word(FUNC_EOL, 8'h00);
      add_text("acgt");
      add_word(FUNC_EOL, 8'h00);
      add_word(FUNC_UNUSED, 8'h41);
      add_word(FUNC_REPORT, 8'hFF);
      add_text("TG");
      add_word(FUNC_REPORT, 8'h55);
      add_text("CA");
      add_word(FUNC_EOL, 8'hAA);
      add_word(FUNC_REPORT, 8'h00, 1'b1);

      while (pending_words.size() < 420) begin
         if (pending_words.size() > 200 && pending_words.size() < 230
             && $urandom_range(0, 3) == 0) begin
            add_word(FUNC_REPORT, 8'($urandom_range(0, 255)), 1'b1);
         end else if ($urandom_range(0, 9) == 0) begin
            add_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            add_random_line($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 5) == 0)
               add_word(FUNC_REPORT, 8'($urandom_range(0, 255)));
         end
      end
      add_word(FUNC_REPORT, 8'h00);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && expected_counts.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_counts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      forever #6 clock = ~clock;
   end

   // Driver: offers the oldest pending word, with random gaps outside the tail.
   int send_gap = 0;
   always @(posedge clock) begin
      word_type head;
      bit    offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         offer = 0;
         if (req_ch.valid && req_ch.ready) begin
            update_histogram(pending_words.pop_front());
         end
         if (req_ch.valid && !req_ch.ready) begin
            offer = 1;
         end else if (send_gap > 0) begin
            send_gap--;
         end else if (pending_words.size() > 0) begin
            head = pending_words[0];
            if (!(head.drain && expected_counts.size() != 0)) begin
               offer = 1;
               req_ch.func <= head.func;
               req_ch.symbol <= head.symbol;
               if (pending_words.size() > 80 && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 10);
            end
         end
         req_ch.valid <= offer;
      end
   end

   // A single long hold on the response side lets the input back up.
   int  long_hold = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && report_count >= 5) begin
            hold_done = 1;
            long_hold = 400;
         end else if (long_hold > 0) begin
            long_hold--;
         end
      end
   end

   // Monitor: checks every accepted count word against the oldest expectation.
   int rsp_gap = 0;
   always @(posedge clock) begin
      count_word_type exp_w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_counts.size() == 0) begin
               $error("unexpected count word: index %0d value %0d",
                      rsp_ch.item_index, rsp_ch.count_value);
               fail_count++;
            end else begin
               exp_w = expected_counts.pop_front();
               if (rsp_ch.item_index !== exp_w.item_index) begin
                  $error("item_index: expected %0d, actual %0d",
                         exp_w.item_index, rsp_ch.item_index);
                  fail_count++;
               end
               if (rsp_ch.count_value !== exp_w.count_value) begin
                  $error("count_value: expected %0d, actual %0d",
                         exp_w.count_value, rsp_ch.count_value);
                  fail_count++;
               end
               if (rsp_ch.last_item !== exp_w.last_item) begin
                  $error("last_item: expected %0d, actual %0d",
                         exp_w.last_item, rsp_ch.last_item);
                  fail_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (pending_words.size() > 80 && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule

@@ nucleotide_pair_histogram.f @@
rtl/core/nph_pkg.sv
rtl/core/nph_if.sv
rtl/core/nph_front.sv
rtl/core/nph_back.sv
rtl/core/nucleotide_pair_histogram.sv
tb/sv/nucleotide_pair_histogram_test.sv
